### src/hcbp_pkg.sv
package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;

    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int SYM_W     = 8;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 3;
    localparam int TBL_AW    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int CODE_LIM  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } hcbp_entry_t;

endpackage

### src/hcbp_code_table.sv
module hcbp_code_table (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [hcbp_pkg::TBL_AW-1:0] wr_addr,
    input  hcbp_pkg::hcbp_entry_t      wr_data,
    input  logic                       rd_en,
    input  logic [hcbp_pkg::TBL_AW-1:0] rd_addr,
    output hcbp_pkg::hcbp_entry_t      rd_data
);
    import hcbp_pkg::*;

    hcbp_entry_t mem [SYMBOL_COUNT];
    hcbp_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/huffman_code_bit_packer.sv
// load: no result; flush: at most one byte
// encode: table read and setup, then the shift unit takes the code in chunks, each filling
//   the pending byte up to a byte boundary or to the end of the code
// one item at a time: item_stall stays high until the sequencer returns to idle
// a stalled result channel holds the shift unit; otherwise bytes leave one per cycle
// rst_n is asynchronous: clears pending byte, bit count, sequencer and result valid
module huffman_code_bit_packer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    opcode,
    input  logic [hcbp_pkg::SYM_W-1:0]    symbol,
    input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
    input  logic [hcbp_pkg::CODE_W-1:0]   code_word,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [hcbp_pkg::BYTE_W-1:0]   packed_byte,
    output logic                          last_of_run
);
    import hcbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_FLUSH
    } state_t;

    state_t              state_reg, state_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [BYTE_W-1:0]   pend_reg, pend_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                rvalid_reg, rvalid_next;
    logic [BYTE_W-1:0]   rbyte_reg, rbyte_next;
    logic                rlast_reg, rlast_next;

    logic                accept;
    logic                sym_ok;
    logic                can_step;
    logic [LEN_W-1:0]    len_sat;
    logic [LEN_W-1:0]    align_sh;
    hcbp_entry_t         wr_entry;
    hcbp_entry_t         rd_entry;
    logic                wr_en;
    logic                rd_en;

    logic [CNT_W:0]      space;
    logic [CNT_W:0]      take;
    logic [CNT_W:0]      fill;
    logic [BYTE_W-1:0]   merged;
    logic [LEN_W-1:0]    rem_after;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign sym_ok     = ({1'b0, symbol} < (SYM_W+1)'(SYMBOL_COUNT));
    assign can_step   = !rvalid_reg || !result_stall;

    // saturate and left-align the code so the first bit sits in the msb
    assign len_sat  = (code_length > LEN_W'(CODE_LIM)) ? LEN_W'(CODE_LIM) : code_length;
    assign align_sh = LEN_W'(CODE_W) - len_sat;
    assign wr_entry.len  = len_sat;
    assign wr_entry.code = code_word << align_sh;
    assign wr_en = accept && (opcode == OP_LOAD) && sym_ok;
    assign rd_en = accept && (opcode == OP_ENCODE) && sym_ok;

    hcbp_code_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (symbol[TBL_AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (symbol[TBL_AW-1:0]),
        .rd_data (rd_entry)
    );

    // shift unit: one chunk of up to a byte per cycle unless the result channel stalls
    assign space     = (CNT_W+1)'(BYTE_W) - {1'b0, cnt_reg};
    assign take      = ({{(LEN_W-CNT_W-1){1'b0}}, space} < rem_reg) ? space
                                                                    : (CNT_W+1)'(rem_reg);
    assign fill      = {1'b0, cnt_reg} + take;
    assign merged    = pend_reg | (code_reg[CODE_W-1 -: BYTE_W] >> cnt_reg);
    assign rem_after = rem_reg - LEN_W'(take);

    always_comb
    begin
        state_next  = state_reg;
        code_next   = code_reg;
        rem_next    = rem_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        rvalid_next = rvalid_reg && result_stall;
        rbyte_next  = rbyte_reg;
        rlast_next  = rlast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_ENCODE && sym_ok)
                    begin
                        state_next = ST_READ;
                    end
                    else if (opcode == OP_FLUSH)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_READ:
            begin
                code_next = rd_entry.code;
                rem_next  = (rd_entry.len > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : rd_entry.len;
                if (rd_entry.len == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (can_step)
                begin
                    code_next = code_reg << take;
                    rem_next  = rem_after;
                    cnt_next  = fill[CNT_W-1:0];
                    if (fill[CNT_W])
                    begin
                        pend_next   = '0;
                        rvalid_next = 1'b1;
                        rbyte_next  = merged;
                        // after a full byte only a whole further byte can follow
                        rlast_next  = (rem_after < LEN_W'(BYTE_W));
                    end
                    else
                    begin
                        pend_next = merged;
                    end
                    if (rem_after == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (cnt_reg == '0)
                begin
                    pend_next  = '0;
                    state_next = ST_IDLE;
                end
                else if (can_step)
                begin
                    rvalid_next = 1'b1;
                    rbyte_next  = pend_reg;
                    rlast_next  = 1'b1;
                    pend_next   = '0;
                    cnt_next    = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            code_reg   <= '0;
            rem_reg    <= '0;
            pend_reg   <= '0;
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
            rbyte_reg  <= '0;
            rlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            code_reg   <= code_next;
            rem_reg    <= rem_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= rvalid_next;
            rbyte_reg  <= rbyte_next;
            rlast_reg  <= rlast_next;
        end
    end

    assign result_valid = rvalid_reg;
    assign packed_byte  = rbyte_reg;
    assign last_of_run  = rlast_reg;

`ifndef NO_ASSERTIONS
    a_shift_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT |-> (rem_reg != '0) && (rem_reg <= LEN_W'(CODE_W)))
        else $error("shift state with no bits left");

    a_encode_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_ENCODE) && sym_ok |=> item_stall)
        else $error("encode item did not start the sequencer");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) && rvalid_reg && result_stall
            |=> $stable(rem_reg) && $stable(cnt_reg))
        else $error("shift unit advanced while result was blocked");
`endif

endmodule

### tb/huffman_code_bit_packer_tb.sv
module huffman_code_bit_packer_tb;
    import hcbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS   = 140;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AT        = 40;
    localparam int HOLD_LEN       = 300;
    localparam int DRAIN_CYCLES   = 20;

    class code_pack_checker;
        typedef struct packed {
            logic [BYTE_W-1:0] value;
            logic              last;
        } due_t;

        logic [LEN_W-1:0]  tbl_len  [SYMBOL_COUNT];
        logic [CODE_W-1:0] tbl_code [SYMBOL_COUNT];
        bit                known    [SYMBOL_COUNT];
        logic [SYM_W-1:0]  known_syms[$];
        logic [BYTE_W-1:0] part_byte;
        int unsigned       part_bits;
        due_t              bytes_due[$];
        int                errors;
        int                n_loads;
        int                n_encodes;
        int                n_flushes;
        int                n_other;
        int                n_bytes;

        function new();
            part_byte = '0;
            part_bits = 0;
        endfunction

        function void push_byte();
            due_t d;
            d.value = part_byte;
            d.last  = 1'b0;
            bytes_due.push_back(d);
            part_byte = '0;
            part_bits = 0;
        endfunction

        function void note_item(logic [1:0] op, logic [SYM_W-1:0] sym,
                                logic [LEN_W-1:0] len, logic [CODE_W-1:0] word);
            int unsigned lim_len;
            int unsigned k;
            int          before_n;
            before_n = bytes_due.size();
            case (op)
                OP_LOAD:
                begin
                    n_loads++;
                    if (sym < SYMBOL_COUNT)
                    begin
                        lim_len = (len > CODE_LIM) ? CODE_LIM : 32'(len);
                        if (lim_len < CODE_W)
                            word = word & ((32'd1 << lim_len) - 32'd1);
                        tbl_len[sym]  = lim_len[LEN_W-1:0];
                        tbl_code[sym] = word;
                        if (!known[sym])
                            known_syms.push_back(sym);
                        known[sym] = 1'b1;
                    end
                end
                OP_ENCODE:
                begin
                    n_encodes++;
                    if (sym < SYMBOL_COUNT && known[sym])
                    begin
                        for (k = 32'(tbl_len[sym]); k > 0; k--)
                        begin
                            part_byte[7 - part_bits] = tbl_code[sym][k - 1];
                            part_bits++;
                            if (part_bits == 8)
                                push_byte();
                        end
                    end
                end
                OP_FLUSH:
                begin
                    n_flushes++;
                    if (part_bits != 0)
                        push_byte();
                    part_byte = '0;
                    part_bits = 0;
                end
                OP_SPARE:
                    n_other++;
            endcase
            if (bytes_due.size() > before_n)
                bytes_due[bytes_due.size() - 1].last = 1'b1;
        endfunction

        function void check_byte(logic [BYTE_W-1:0] value, logic last);
            due_t d;
            n_bytes++;
            if (bytes_due.size() == 0)
            begin
                $error("unexpected item: packed_byte %02h last_of_run %0b", value, last);
                errors++;
                return;
            end
            d = bytes_due.pop_front();
            if (value !== d.value)
            begin
                $error("packed_byte: expected %02h, actual %02h", d.value, value);
                errors++;
            end
            if (last !== d.last)
            begin
                $error("last_of_run: expected %0b, actual %0b", d.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic [1:0]        opcode = OP_LOAD;
    logic [SYM_W-1:0]  symbol = '0;
    logic [LEN_W-1:0]  code_length = '0;
    logic [CODE_W-1:0] code_word = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [BYTE_W-1:0] packed_byte;
    logic              last_of_run;

    code_pack_checker sb;
    bit tx_burst;
    bit rx_burst;
    int rx_count;
    int rx_wait;
    int rx_hold;
    int idle_cycles;

    huffman_code_bit_packer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .symbol       (symbol),
        .code_length  (code_length),
        .code_word    (code_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .packed_byte  (packed_byte),
        .last_of_run  (last_of_run)
    );

    always #4 clk = ~clk;

    // valid stays high from one accepted item into the next when there is no gap
    task automatic send_item(logic [1:0] op, logic [SYM_W-1:0] sym,
                             logic [LEN_W-1:0] len, logic [CODE_W-1:0] word);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        opcode      <= op;
        symbol      <= sym;
        code_length <= len;
        code_word   <= word;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(op, sym, len, word);
    endtask

    task automatic send_random_item();
        int               r;
        logic [SYM_W-1:0] s;
        logic [LEN_W-1:0] l;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            s = SYM_W'($urandom_range(0, SYMBOL_COUNT - 1));
            if ($urandom_range(0, 9) == 0)
                l = LEN_W'($urandom_range(CODE_LIM + 1, (1 << LEN_W) - 1));
            else
                l = LEN_W'($urandom_range(0, CODE_LIM));
            send_item(OP_LOAD, s, l, $urandom);
        end
        else if (r < 75)
        begin
            s = sb.known_syms[$urandom_range(0, sb.known_syms.size() - 1)];
            send_item(OP_ENCODE, s, LEN_W'($urandom), $urandom);
        end
        else if (r < 93)
            send_item(OP_FLUSH, SYM_W'($urandom), LEN_W'($urandom), $urandom);
        else
            send_item(OP_SPARE, SYM_W'($urandom), LEN_W'($urandom), $urandom);
    endtask

    // result side: per-item stall, plus one long hold-off to back up the input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                sb.check_byte(packed_byte, last_of_run);
                rx_count++;
                if (rx_count % 16 == 0)
                    rx_burst = ($urandom_range(0, 2) == 0);
                rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
                if (rx_count == HOLD_AT)
                    rx_hold = HOLD_LEN;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                result_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        send_item(OP_FLUSH, 8'h00, 6'd0, 32'h0000_0000);
        send_item(OP_SPARE, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 8'h00, 6'd0, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 8'h01, 6'h3F, 32'hA5A5_A5A5);
        send_item(OP_LOAD, 8'h02, 6'd33, 32'h1234_5678);
        send_item(OP_LOAD, 8'h03, 6'd1, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 8'h80, 6'd7, 32'h0000_0055);
        send_item(OP_ENCODE, 8'h00, 6'h3F, 32'hFFFF_FFFF);
        send_item(OP_ENCODE, 8'h03, 6'd0, 32'h0000_0000);
        send_item(OP_ENCODE, 8'hFF, 6'd0, 32'h0000_0000);
        send_item(OP_FLUSH, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
        send_item(OP_FLUSH, 8'h00, 6'd0, 32'h0000_0000);
        send_item(OP_ENCODE, 8'h01, 6'd0, 32'h0000_0000);
        send_item(OP_ENCODE, 8'h02, 6'd0, 32'h0000_0000);
        send_item(OP_ENCODE, 8'h80, 6'd0, 32'h0000_0000);
        send_item(OP_ENCODE, 8'h03, 6'd0, 32'h0000_0000);
        send_item(OP_ENCODE, 8'h80, 6'd0, 32'h0000_0000);
        send_item(OP_ENCODE, 8'hFF, 6'd0, 32'h0000_0000);
        send_item(OP_FLUSH, 8'h00, 6'd0, 32'h0000_0000);
        send_item(OP_LOAD, 8'hFF, 6'd0, 32'h0000_0000);
        send_item(OP_ENCODE, 8'hFF, 6'd0, 32'h0000_0000);
        send_item(OP_SPARE, 8'h00, 6'd0, 32'h0000_0000);

        // random
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 20 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            send_random_item();
        end
        item_valid <= 1'b0;

        while (sb.bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d loads, %0d encodes, %0d flushes, %0d unused-opcode items",
                 sb.n_loads, sb.n_encodes, sb.n_flushes, sb.n_other);
        $display("summary: %0d packed bytes compared, %0d distinct symbols loaded",
                 sb.n_bytes, sb.known_syms.size());
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### filelist.f
src/hcbp_pkg.sv
src/hcbp_code_table.sv
src/huffman_code_bit_packer.sv
tb/huffman_code_bit_packer_tb.sv
